[hw/rtl/flpf_pkg.sv]
// Types and constants shared by the first-order low-pass filter modules.
`timescale 1ns / 1ps
`default_nettype none
package flpf_pkg;

  localparam int unsigned DataWidth   = 32;
  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CfgIdxWidth = 1;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned DivSteps    = 16;
  localparam int unsigned CountWidth  = 4;
  localparam int unsigned DiffWidth   = DataWidth + 1;
  localparam int unsigned ProdWidth   = DiffWidth + FracBits;

  localparam logic [CfgIdxWidth-1:0] RegTimeConstant = 1'b0;
  localparam logic [CfgIdxWidth-1:0] RegScanPeriod   = 1'b1;

  localparam logic [CfgWidth-1:0]   DefaultPeriodMs = 16'd10;
  localparam logic [CountWidth-1:0] LastStep        = 4'(DivSteps - 1);

  typedef enum logic [1:0] {
    StIdle,
    StDivide,
    StMultiply,
    StCommit
  } ctrl_state_e;

  typedef struct packed {
    logic start;
    logic div_step;
    logic mul_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic tau_zero;
  } dp_status_t;

endpackage
`default_nettype wire

[hw/rtl/first_order_low_pass_filter_unit.sv]
// Top level of the first-order low-pass filter (exponential moving average).
//
//   Channel  Direction  Handshake                Payload
//   input    in         in_valid_i / in_ready_o  sample_i (Q15.16, signed)
//   output   out        out_valid_o / out_ready_i filtered_o (Q15.16, signed)
//   config   in         cfg_we_i                 cfg_index_i, cfg_data_i
//
// With a nonzero time constant a request passes through 16 steps of the serial
// alpha divider, 16 steps of the shift-add multiplier and a commit step. With a
// zero time constant it goes from acceptance straight to the commit step.
// One request is in work at a time; the next one is taken while a result waits.
// Reset clears the filter state to zero, the time constant to zero and the
// scan period to ten milliseconds.
`timescale 1ns / 1ps
`default_nettype none
module first_order_low_pass_filter_unit (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [flpf_pkg::CfgIdxWidth-1:0]      cfg_index_i,
  input  wire logic [flpf_pkg::CfgWidth-1:0]         cfg_data_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic signed [flpf_pkg::DataWidth-1:0] sample_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [flpf_pkg::DataWidth-1:0]      filtered_o
);

  flpf_pkg::dp_cmd_t    cmd;
  flpf_pkg::dp_status_t status;

  flpf_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  flpf_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (sample_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .filtered_o  (filtered_o)
  );

endmodule
`default_nettype wire

[hw/rtl/flpf_datapath.sv]
// Datapath: configuration registers, serial divider, serial multiplier and filter state.
`timescale 1ns / 1ps
`default_nettype none
module flpf_datapath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [flpf_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  wire logic [flpf_pkg::CfgWidth-1:0]        cfg_data_i,
  input  wire logic signed [flpf_pkg::DataWidth-1:0] sample_i,
  input  wire flpf_pkg::dp_cmd_t                    cmd_i,
  output flpf_pkg::dp_status_t                      status_o,
  output logic signed [flpf_pkg::DataWidth-1:0]     filtered_o
);

  logic [flpf_pkg::CfgWidth-1:0]   tau_q, period_q;
  logic [flpf_pkg::DataWidth-1:0]  x_q, prev_q, out_q, y;
  logic                            bypass_q;
  logic [flpf_pkg::CfgWidth:0]     divisor_q, rem_q;
  logic [flpf_pkg::CfgWidth-1:0]   quo_q;
  logic [flpf_pkg::ProdWidth-1:0]  acc_q, mcand_q;
  logic [flpf_pkg::CfgWidth-1:0]   dt;
  logic [flpf_pkg::DiffWidth-1:0]  diff;
  logic [flpf_pkg::CfgWidth+1:0]   trial;

  assign dt    = (period_q == '0) ? flpf_pkg::DefaultPeriodMs : period_q;
  assign diff  = {sample_i[flpf_pkg::DataWidth-1], sample_i} -
                 {prev_q[flpf_pkg::DataWidth-1], prev_q};
  assign trial = {rem_q, 1'b0} - {1'b0, divisor_q};
  assign y     = bypass_q ? x_q
               : prev_q + acc_q[flpf_pkg::FracBits +: flpf_pkg::DataWidth];

  assign status_o.tau_zero = (tau_q == '0);
  assign filtered_o        = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tau_q    <= '0;
      period_q <= flpf_pkg::DefaultPeriodMs;
      prev_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          flpf_pkg::RegTimeConstant: tau_q    <= cfg_data_i;
          flpf_pkg::RegScanPeriod:   period_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        prev_q <= y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q       <= sample_i;
      bypass_q  <= (tau_q == '0);
      divisor_q <= {1'b0, tau_q} + {1'b0, dt};
      rem_q     <= {1'b0, dt};
      quo_q     <= '0;
      acc_q     <= '0;
      mcand_q   <= {{flpf_pkg::FracBits{diff[flpf_pkg::DiffWidth-1]}}, diff};
    end
    if (cmd_i.div_step) begin
      if (!trial[flpf_pkg::CfgWidth+1]) begin
        rem_q <= trial[flpf_pkg::CfgWidth:0];
        quo_q <= {quo_q[flpf_pkg::CfgWidth-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[flpf_pkg::CfgWidth-1:0], 1'b0};
        quo_q <= {quo_q[flpf_pkg::CfgWidth-2:0], 1'b0};
      end
    end
    if (cmd_i.mul_step) begin
      if (quo_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q <= {mcand_q[flpf_pkg::ProdWidth-2:0], 1'b0};
      quo_q   <= {1'b0, quo_q[flpf_pkg::CfgWidth-1:1]};
    end
    if (cmd_i.commit) begin
      out_q <= y;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/flpf_controller.sv]
// Controller: sequences the divide and multiply steps and owns the handshakes.
`timescale 1ns / 1ps
`default_nettype none
module flpf_controller (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire flpf_pkg::dp_status_t status_i,
  output flpf_pkg::dp_cmd_t         cmd_o
);

  flpf_pkg::ctrl_state_e               state_q, state_d;
  logic [flpf_pkg::CountWidth-1:0]     cnt_q, cnt_d;
  logic                                out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= flpf_pkg::StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      flpf_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          cnt_d       = '0;
          state_d     = status_i.tau_zero ? flpf_pkg::StCommit : flpf_pkg::StDivide;
        end
      end
      flpf_pkg::StDivide: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == flpf_pkg::LastStep) begin
          state_d = flpf_pkg::StMultiply;
        end
      end
      flpf_pkg::StMultiply: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == flpf_pkg::LastStep) begin
          state_d = flpf_pkg::StCommit;
        end
      end
      flpf_pkg::StCommit: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = flpf_pkg::StIdle;
        end
      end
      default: begin
        state_d = flpf_pkg::StIdle;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire
